[rtl/jhb_pkg.sv]
// Shared constants, types and register indexes of the joint histogram block.
`default_nettype none

package jhb_pkg;

    // Store geometry and field widths
    localparam int MAX_LEFT_BINS  = 64;
    localparam int MAX_RIGHT_BINS = 64;
    localparam int COUNT_WIDTH    = 32;
    localparam int PIXEL_WIDTH    = 16;
    localparam int BIN_W          = 6;
    localparam int ADDR_W         = 12;
    localparam int BCNT_W         = 7;
    localparam int FRAC_BITS      = 8;
    localparam int NUM_W          = PIXEL_WIDTH + FRAC_BITS;
    localparam int STEP_W         = 3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COUNT = 3'd5;

    // Request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Queue between the front and the back
    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = 2;

    // One classified operation for the back end
    typedef struct packed {
        logic             rd;
        logic [BIN_W-1:0] row;
        logic [BIN_W-1:0] col;
    } op_t;

endpackage

`default_nettype wire

[rtl/jhb_fifo.sv]
// Short queue of classified operations between the front and the back end.
`default_nettype none

module jhb_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    output logic             wr_full,
    input  wire jhb_pkg::op_t wr_data,
    input  wire logic        rd_en,
    output logic             rd_empty,
    output jhb_pkg::op_t     rd_data
);

    jhb_pkg::op_t                data_reg [jhb_pkg::MID_DEPTH];
    logic [jhb_pkg::MID_AW-1:0]  wptr_reg;
    logic [jhb_pkg::MID_AW-1:0]  rptr_reg;
    logic [jhb_pkg::MID_AW:0]    fill_reg;
    logic [jhb_pkg::MID_AW:0]    fill_next;
    logic                        do_wr;
    logic                        do_rd;

    assign wr_full  = (fill_reg == (jhb_pkg::MID_AW + 1)'(jhb_pkg::MID_DEPTH));
    assign rd_empty = (fill_reg == '0);
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && !rd_empty;
    assign rd_data  = data_reg[rptr_reg];

    // Fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/jhb_front.sv]
// Front end: configuration registers, request intake and bin index divider.
`default_nettype none

module jhb_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [jhb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [jhb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            accept,
    output logic                                 busy,
    input  wire logic                            req_type,
    input  wire logic [jhb_pkg::PIXEL_WIDTH-1:0] left_pixel,
    input  wire logic [jhb_pkg::PIXEL_WIDTH-1:0] right_pixel,
    input  wire logic [jhb_pkg::BIN_W-1:0]       read_row,
    input  wire logic [jhb_pkg::BIN_W-1:0]       read_col,
    output logic                                 op_push,
    input  wire logic                            op_full,
    output jhb_pkg::op_t                         op_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg;
    front_state_t state_next;

    // Configuration
    logic [jhb_pkg::PIXEL_WIDTH-1:0] low_reg   [2];
    logic [jhb_pkg::CFG_DATA_W-1:0]  width_reg [2];
    logic [jhb_pkg::BCNT_W-1:0]      bcnt_reg  [2];

    // Per lane divider state (lane 0 left, lane 1 right)
    logic [jhb_pkg::NUM_W-1:0]  rem_reg  [2];
    logic [jhb_pkg::NUM_W-1:0]  rem_next [2];
    logic [jhb_pkg::BIN_W-1:0]  q_reg    [2];
    logic [jhb_pkg::BIN_W-1:0]  q_next   [2];
    logic                       done_reg [2];
    logic                       done_next[2];
    logic [jhb_pkg::STEP_W-1:0] step_reg;
    logic [jhb_pkg::STEP_W-1:0] step_next;
    logic                       rd_reg;
    logic                       rd_next;

    // Lane helpers
    logic [jhb_pkg::PIXEL_WIDTH-1:0] pix     [2];
    logic [jhb_pkg::BIN_W-1:0]       rd_bin  [2];
    logic [jhb_pkg::PIXEL_WIDTH:0]   diff    [2];
    logic [jhb_pkg::NUM_W-1:0]       num     [2];
    logic [jhb_pkg::NUM_W-1:0]       sub_w   [2];
    logic [jhb_pkg::BIN_W-1:0]       lim     [2];
    logic [jhb_pkg::BIN_W-1:0]       bin_out [2];
    logic                            nonpos  [2];
    logic                            big     [2];

    assign pix[0]    = left_pixel;
    assign pix[1]    = right_pixel;
    assign rd_bin[0] = read_row;
    assign rd_bin[1] = read_col;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg[0]   <= '0;
            low_reg[1]   <= '0;
            width_reg[0] <= 16'd256;
            width_reg[1] <= 16'd256;
            bcnt_reg[0]  <= 7'd64;
            bcnt_reg[1]  <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                jhb_pkg::CFG_LEFT_LOW:    low_reg[0]   <= cfg_data;
                jhb_pkg::CFG_LEFT_WIDTH:  width_reg[0] <= cfg_data;
                jhb_pkg::CFG_LEFT_COUNT:  bcnt_reg[0]  <= cfg_data[jhb_pkg::BCNT_W-1:0];
                jhb_pkg::CFG_RIGHT_LOW:   low_reg[1]   <= cfg_data;
                jhb_pkg::CFG_RIGHT_WIDTH: width_reg[1] <= cfg_data;
                jhb_pkg::CFG_RIGHT_COUNT: bcnt_reg[1]  <= cfg_data[jhb_pkg::BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Lane classification, divider step and final clamp
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            // last bin in use: zero counts as one bin, large counts stop at the store edge
            if (bcnt_reg[l] == '0)
            begin
                lim[l] = '0;
            end
            else if (bcnt_reg[l] > jhb_pkg::BCNT_W'((l == 0) ? jhb_pkg::MAX_LEFT_BINS
                                                             : jhb_pkg::MAX_RIGHT_BINS))
            begin
                lim[l] = jhb_pkg::BIN_W'(((l == 0) ? jhb_pkg::MAX_LEFT_BINS
                                                   : jhb_pkg::MAX_RIGHT_BINS) - 1);
            end
            else
            begin
                lim[l] = jhb_pkg::BIN_W'(bcnt_reg[l] - 1'b1);
            end
            diff[l]   = {pix[l][jhb_pkg::PIXEL_WIDTH-1], pix[l]}
                      - {low_reg[l][jhb_pkg::PIXEL_WIDTH-1], low_reg[l]};
            nonpos[l] = diff[l][jhb_pkg::PIXEL_WIDTH] || (diff[l] == '0);
            num[l]    = {diff[l][jhb_pkg::PIXEL_WIDTH-1:0], {jhb_pkg::FRAC_BITS{1'b0}}};
            // quotient beyond the bin range, or zero width: last bin
            big[l]    = (width_reg[l] == '0)
                     || (num[l] >= (jhb_pkg::NUM_W'(width_reg[l]) << jhb_pkg::BIN_W));
            sub_w[l]  = jhb_pkg::NUM_W'(width_reg[l]) << step_reg;
            bin_out[l] = (!rd_reg && (q_reg[l] > lim[l])) ? lim[l] : q_reg[l];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rd_next    = rd_reg;
        for (int l = 0; l < 2; l++)
        begin
            rem_next[l]  = rem_reg[l];
            q_next[l]    = q_reg[l];
            done_next[l] = done_reg[l];
        end
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    rd_next   = req_type;
                    step_next = jhb_pkg::STEP_W'(jhb_pkg::BIN_W - 1);
                    for (int l = 0; l < 2; l++)
                    begin
                        rem_next[l] = num[l];
                        if (req_type == jhb_pkg::REQ_READ)
                        begin
                            q_next[l]    = rd_bin[l];
                            done_next[l] = 1'b1;
                        end
                        else if (nonpos[l])
                        begin
                            q_next[l]    = '0;
                            done_next[l] = 1'b1;
                        end
                        else if (big[l])
                        begin
                            q_next[l]    = lim[l];
                            done_next[l] = 1'b1;
                        end
                        else
                        begin
                            q_next[l]    = '0;
                            done_next[l] = 1'b0;
                        end
                    end
                    state_next = (req_type == jhb_pkg::REQ_READ) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                // one restoring quotient bit per cycle in both lanes
                for (int l = 0; l < 2; l++)
                begin
                    if (!done_reg[l] && (rem_reg[l] >= sub_w[l]))
                    begin
                        rem_next[l]         = rem_reg[l] - sub_w[l];
                        q_next[l][step_reg] = 1'b1;
                    end
                end
                if (step_reg == '0)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            F_PUSH:
            begin
                if (!op_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rd_reg   <= rd_next;
        for (int l = 0; l < 2; l++)
        begin
            rem_reg[l]  <= rem_next[l];
            q_reg[l]    <= q_next[l];
            done_reg[l] <= done_next[l];
        end
    end

    assign busy        = (state_reg != F_IDLE);
    assign op_push     = (state_reg == F_PUSH);
    assign op_data.rd  = rd_reg;
    assign op_data.row = bin_out[0];
    assign op_data.col = bin_out[1];

endmodule

`default_nettype wire

[rtl/jhb_back.sv]
// Back end: count store with clearing pass, read-modify-write and result register.
`default_nettype none

module jhb_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              op_empty,
    output logic                                   op_pop,
    input  wire jhb_pkg::op_t                      op_data,
    output logic                                   clearing,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [jhb_pkg::BIN_W-1:0]              row_bin,
    output logic [jhb_pkg::BIN_W-1:0]              col_bin,
    output logic [jhb_pkg::COUNT_WIDTH-1:0]        bin_count,
    output logic                                   saturated
);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_UPD   = 4'b1000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [jhb_pkg::COUNT_WIDTH-1:0] mem [1 << jhb_pkg::ADDR_W];
    logic [jhb_pkg::COUNT_WIDTH-1:0] rd_data_reg;
    logic [jhb_pkg::ADDR_W-1:0]      clr_addr_reg;
    jhb_pkg::op_t                    cur_reg;
    logic                            out_valid_reg;
    logic [jhb_pkg::BIN_W-1:0]       row_reg;
    logic [jhb_pkg::BIN_W-1:0]       col_reg;
    logic [jhb_pkg::COUNT_WIDTH-1:0] cnt_reg;
    logic                            sat_reg;

    logic [jhb_pkg::ADDR_W-1:0]      rd_addr;
    logic [jhb_pkg::ADDR_W-1:0]      wr_addr;
    logic [jhb_pkg::COUNT_WIDTH-1:0] wr_data;
    logic                            wr_en;
    logic [jhb_pkg::COUNT_WIDTH-1:0] new_cnt;
    logic                            new_sat;
    logic                            out_take;

    assign out_take = pop && out_valid_reg;
    assign op_pop   = (state_reg == B_IDLE) && !op_empty && (!out_valid_reg || pop);
    assign rd_addr  = {op_data.row, op_data.col};
    assign clearing = (state_reg == B_CLEAR);

    // New count and write-back value
    always_comb
    begin
        new_sat = 1'b0;
        if (cur_reg.rd == jhb_pkg::REQ_READ)
        begin
            new_cnt = rd_data_reg;
            wr_data = '0;
        end
        else if (rd_data_reg == jhb_pkg::COUNT_MAX)
        begin
            new_cnt = rd_data_reg;
            new_sat = 1'b1;
            wr_data = rd_data_reg;
        end
        else
        begin
            new_cnt = rd_data_reg + 1'b1;
            wr_data = new_cnt;
        end
        if (state_reg == B_CLEAR)
        begin
            wr_addr = clr_addr_reg;
            wr_data = '0;
            wr_en   = 1'b1;
        end
        else
        begin
            wr_addr = {cur_reg.row, cur_reg.col};
            wr_en   = (state_reg == B_UPD);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (op_pop)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_UPD;
            end
            B_UPD:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == B_UPD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Count store: one write per cycle, read captured when an operation is taken
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (op_pop)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Operation in flight and result register
    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            cur_reg <= op_data;
        end
        if (state_reg == B_UPD)
        begin
            row_reg <= cur_reg.row;
            col_reg <= cur_reg.col;
            cnt_reg <= new_cnt;
            sat_reg <= new_sat;
        end
    end

    assign empty     = !out_valid_reg;
    assign row_bin   = row_reg;
    assign col_bin   = col_reg;
    assign bin_count = cnt_reg;
    assign saturated = sat_reg;

    // A result appears only out of the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_UPD))
        else $error("result raised outside update");

    // Update follows the store read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_UPD) |-> $past(state_reg == B_READ))
        else $error("update without store read");

    // No operation taken while the store is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !op_pop)
        else $error("operation taken during clearing");

    // A saturated result always carries the maximum count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (cnt_reg == jhb_pkg::COUNT_MAX))
        else $error("saturation flag without maximum count");

endmodule

`default_nettype wire

[rtl/joint_histogram_binning.sv]
// Top level of the joint histogram: front end, operation queue and count store.
//
//  channel   | handshake            | fields
//  ----------+----------------------+--------------------------------------------
//  request   | push / full          | req_type, left_pixel, right_pixel,
//            |                      | read_row, read_col
//  result    | empty / pop          | row_bin, col_bin, bin_count, saturated
//  config    | cfg_write            | cfg_index, cfg_data
//
// An add request occupies the front end through intake, six quotient steps of
// the restoring divider in each lane and the queue push; a read skips the steps.
// The back end takes one operation at a time through a store read and write-back.
// After reset a clearing pass writes zero to all 4096 counters, one per cycle;
// full stays high throughout the pass. A result waiting on the output register
// stalls the back end; the front end keeps filling the queue until it is full.
`default_nettype none

module joint_histogram_binning (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [jhb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [jhb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            req_type,
    input  wire logic [jhb_pkg::PIXEL_WIDTH-1:0] left_pixel,
    input  wire logic [jhb_pkg::PIXEL_WIDTH-1:0] right_pixel,
    input  wire logic [jhb_pkg::BIN_W-1:0]       read_row,
    input  wire logic [jhb_pkg::BIN_W-1:0]       read_col,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [jhb_pkg::BIN_W-1:0]            row_bin,
    output logic [jhb_pkg::BIN_W-1:0]            col_bin,
    output logic [jhb_pkg::COUNT_WIDTH-1:0]      bin_count,
    output logic                                 saturated
);

    logic         front_busy;
    logic         clearing;
    logic         accept;
    logic         op_push;
    logic         op_full;
    logic         op_pop;
    logic         op_empty;
    jhb_pkg::op_t op_wdata;
    jhb_pkg::op_t op_rdata;

    // Request transfer
    assign full   = front_busy || clearing;
    assign accept = push && !full;

    jhb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .busy        (front_busy),
        .req_type    (req_type),
        .left_pixel  (left_pixel),
        .right_pixel (right_pixel),
        .read_row    (read_row),
        .read_col    (read_col),
        .op_push     (op_push),
        .op_full     (op_full),
        .op_data     (op_wdata)
    );

    jhb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (op_push),
        .wr_full  (op_full),
        .wr_data  (op_wdata),
        .rd_en    (op_pop),
        .rd_empty (op_empty),
        .rd_data  (op_rdata)
    );

    jhb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .op_data   (op_rdata),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .row_bin   (row_bin),
        .col_bin   (col_bin),
        .bin_count (bin_count),
        .saturated (saturated)
    );

endmodule

`default_nettype wire
